// ===== sv/integer_matrix_multiply_defines.svh =====
// assertion macros shared by the matrix multiply rtl
// relies on signals named clk and rst_n in the module that expands them
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/imm_pkg.sv =====
// shared types and constants for the matrix multiply block
// no dependencies
`timescale 1ns / 1ps

package imm_pkg;

  localparam int ELEM_W     = 32;
  localparam int IDX_OUT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = CFG_DATA_W'(8);

  // controller to datapath
  typedef struct packed {
    logic                 a_wr;
    logic                 b_wr;
    logic                 rd;
    logic                 rd_first;
    logic                 rd_last;
    logic                 emit;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 last;
  } imm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } imm_sts_t;

endpackage

// ===== sv/imm_in_if.sv =====
// element input channel
// depends on imm_pkg
`timescale 1ns / 1ps

interface imm_in_if;
  import imm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

// ===== sv/imm_out_if.sv =====
// result output channel
// depends on imm_pkg
`timescale 1ns / 1ps

interface imm_out_if;
  import imm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] product_value;
  logic [IDX_OUT_W-1:0]     row_index;
  logic [IDX_OUT_W-1:0]     col_index;
  logic                     last_result;

  modport source (output valid, output product_value, output row_index,
                  output col_index, output last_result, input ready);
  modport sink   (input valid, input product_value, input row_index,
                  input col_index, input last_result, output ready);
endinterface

// ===== sv/imm_cfg_if.sv =====
// configuration write channel
// depends on imm_pkg
`timescale 1ns / 1ps

interface imm_cfg_if;
  import imm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== sv/imm_ctrl.sv =====
// controller: dimension registers, load counter and entry sequencer
// depends on imm_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "integer_matrix_multiply_defines.svh"

module imm_ctrl #(
  parameter int MAX_DIM = 8,
  parameter int AW      = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [imm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             cfg_ready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  imm_pkg::imm_sts_t                sts,
  output imm_pkg::imm_cmd_t                cmd,
  output logic [AW-1:0]                    wr_addr,
  output logic [AW-1:0]                    a_rd_addr,
  output logic [AW-1:0]                    b_rd_addr
);
  import imm_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int LW = 2 * DW;
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [1:0] {S_LOAD, S_ISSUE, S_WAIT} state_t;

  state_t                state_r;
  logic [CFG_DATA_W-1:0] rows_r, inner_r, cols_r;
  logic                  phase_b_r;
  logic [AW-1:0]         cnt_r;
  logic [IW-1:0]         i_r, j_r, k_r;
  logic [AW-1:0]         a_base_r, a_addr_r, b_addr_r;

  logic [DW-1:0] r_eff, n_eff, c_eff;
  logic [IW-1:0] r_m1, n_m1, c_m1;
  logic [LW-1:0] a_len, b_len;
  logic          cfg_fire, in_fire, a_end, b_end;
  logic [IW-1:0] i_nxt, j_nxt;
  logic [AW-1:0] a_base_nxt;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return DW'(1);
    if (v > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction

  always_comb begin
    r_eff = eff_dim(rows_r);
    n_eff = eff_dim(inner_r);
    c_eff = eff_dim(cols_r);
    r_m1  = IW'(r_eff - DW'(1));
    n_m1  = IW'(n_eff - DW'(1));
    c_m1  = IW'(c_eff - DW'(1));
    a_len = LW'(r_eff) * LW'(n_eff);
    b_len = LW'(n_eff) * LW'(c_eff);
    a_end = (LW'(cnt_r) == a_len - LW'(1));
    b_end = (LW'(cnt_r) == b_len - LW'(1));
  end

  assign cfg_ready = (state_r == S_LOAD);
  assign in_ready  = (state_r == S_LOAD) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.a_wr     = in_fire && !phase_b_r;
    cmd.b_wr     = in_fire && phase_b_r;
    cmd.rd       = (state_r == S_ISSUE);
    cmd.rd_first = (k_r == '0);
    cmd.rd_last  = (k_r == n_m1);
    cmd.emit     = (state_r == S_WAIT) && sts.acc_done && sts.out_free;
    cmd.row      = IDX_OUT_W'(i_r);
    cmd.col      = IDX_OUT_W'(j_r);
    cmd.last     = (i_r == r_m1) && (j_r == c_m1);
  end

  assign wr_addr   = cnt_r;
  assign a_rd_addr = a_addr_r;
  assign b_rd_addr = b_addr_r;

  // next entry position after an emit
  always_comb begin
    i_nxt      = i_r;
    j_nxt      = j_r + IW'(1);
    a_base_nxt = a_base_r;
    if (j_r == c_m1) begin
      i_nxt      = i_r + IW'(1);
      j_nxt      = '0;
      a_base_nxt = a_base_r + AW'(n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      rows_r    <= DIM_RESET;
      inner_r   <= DIM_RESET;
      cols_r    <= DIM_RESET;
      phase_b_r <= 1'b0;
      cnt_r     <= '0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      a_base_r  <= '0;
      a_addr_r  <= '0;
      b_addr_r  <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (cfg_fire) begin
            unique case (cfg_index)
              REG_ROWS_A: begin
                rows_r    <= cfg_data;
                phase_b_r <= 1'b0;
                cnt_r     <= '0;
              end
              REG_INNER_DIM: begin
                inner_r   <= cfg_data;
                phase_b_r <= 1'b0;
                cnt_r     <= '0;
              end
              REG_COLS_B: begin
                cols_r    <= cfg_data;
                phase_b_r <= 1'b0;
                cnt_r     <= '0;
              end
              default: begin
              end
            endcase
          end else if (in_fire) begin
            if (!phase_b_r) begin
              if (a_end) begin
                phase_b_r <= 1'b1;
                cnt_r     <= '0;
              end else begin
                cnt_r <= cnt_r + AW'(1);
              end
            end else if (b_end) begin
              phase_b_r <= 1'b0;
              cnt_r     <= '0;
              i_r       <= '0;
              j_r       <= '0;
              k_r       <= '0;
              a_base_r  <= '0;
              a_addr_r  <= '0;
              b_addr_r  <= '0;
              state_r   <= S_ISSUE;
            end else begin
              cnt_r <= cnt_r + AW'(1);
            end
          end
        end
        S_ISSUE: begin
          if (k_r == n_m1) begin
            state_r <= S_WAIT;
          end else begin
            k_r      <= k_r + IW'(1);
            a_addr_r <= a_addr_r + AW'(1);
            b_addr_r <= b_addr_r + AW'(c_eff);
          end
        end
        S_WAIT: begin
          if (cmd.emit) begin
            if (cmd.last) begin
              state_r <= S_LOAD;
            end else begin
              i_r      <= i_nxt;
              j_r      <= j_nxt;
              k_r      <= '0;
              a_base_r <= a_base_nxt;
              a_addr_r <= a_base_nxt;
              b_addr_r <= AW'(j_nxt);
              state_r  <= S_ISSUE;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  `IMM_ASSERT_NOW(a_no_read_over_result, cmd.rd, !sts.acc_done, "read issued over unsent result")
  `IMM_ASSERT_NOW(a_first_addr, (state_r == S_ISSUE) && (k_r == '0), a_addr_r == a_base_r, "row base mismatch")
  `IMM_ASSERT_NEXT(a_load_to_issue, in_fire && phase_b_r && b_end, state_r == S_ISSUE, "missed compute start")

endmodule

// ===== sv/imm_dp.sv =====
// datapath: element memories, multiply-accumulate pipe and output register
// depends on imm_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "integer_matrix_multiply_defines.svh"

module imm_dp #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  imm_pkg::imm_cmd_t                     cmd,
  output imm_pkg::imm_sts_t                     sts,
  input  logic [AW-1:0]                         wr_addr,
  input  logic [AW-1:0]                         a_rd_addr,
  input  logic [AW-1:0]                         b_rd_addr,
  input  logic signed [imm_pkg::ELEM_W-1:0]     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [imm_pkg::ELEM_W-1:0]     out_value,
  output logic [imm_pkg::IDX_OUT_W-1:0]         out_row,
  output logic [imm_pkg::IDX_OUT_W-1:0]         out_col,
  output logic                                  out_last
);
  import imm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [DATA_WIDTH-1:0] a_mem [DEPTH];
  logic [DATA_WIDTH-1:0] b_mem [DEPTH];

  logic [DATA_WIDTH-1:0] a_q_r, b_q_r, prod_r, acc_r;
  logic                  v1_r, first1_r, last1_r;
  logic                  v2_r, first2_r, last2_r;
  logic                  acc_done_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_value_r;
  logic [IDX_OUT_W-1:0]  out_row_r, out_col_r;
  logic                  out_last_r;

  // element stores, one write port and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.a_wr) a_mem[wr_addr] <= in_data[DATA_WIDTH-1:0];
    if (cmd.b_wr) b_mem[wr_addr] <= in_data[DATA_WIDTH-1:0];
    if (cmd.rd) begin
      a_q_r <= a_mem[a_rd_addr];
      b_q_r <= b_mem[b_rd_addr];
    end
  end

  // product keeps the low bits only, wrapping as two's complement
  always_ff @(posedge clk) begin
    prod_r <= DATA_WIDTH'(a_q_r * b_q_r);
    if (v2_r) acc_r <= first2_r ? prod_r : acc_r + prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      first1_r   <= 1'b0;
      last1_r    <= 1'b0;
      v2_r       <= 1'b0;
      first2_r   <= 1'b0;
      last2_r    <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      v1_r     <= cmd.rd;
      first1_r <= cmd.rd_first;
      last1_r  <= cmd.rd_last;
      v2_r     <= v1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      if (v2_r && last2_r) acc_done_r <= 1'b1;
      else if (cmd.emit)   acc_done_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= acc_r;
      out_row_r   <= cmd.row;
      out_col_r   <= cmd.col;
      out_last_r  <= cmd.last;
    end
  end

  assign sts.acc_done = acc_done_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_value = ELEM_W'(signed'(out_value_r));
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

  `IMM_ASSERT_NOW(a_emit_needs_result, cmd.emit, acc_done_r, "emit without finished sum")
  `IMM_ASSERT_NEXT(a_emit_shows_beat, cmd.emit, out_valid_r, "emitted result not presented")
  `IMM_ASSERT_NEXT(a_sum_completes, v2_r && last2_r, acc_done_r, "final product not flagged")

endmodule

// ===== sv/integer_matrix_multiply.sv =====
// Streaming integer matrix product C = A * B. Elements arrive one per beat on the input
// channel: first the rows_a x inner_dim entries of A row by row, then the inner_dim x cols_b
// entries of B row by row. During loading one element is taken every cycle while no
// register write is pending. The beat that carries the last B element starts a compute
// burst in which the input channel is held off; each entry of C is built by one memory
// read per inner step, then the multiply and accumulate registers, and a hand-over of the
// sum to the output register once it is free. A result still waiting at the output holds
// that hand-over back, so downstream stalls stretch the burst.
// Entries leave row by row with their row and column, and
// last_result marks the final one. A fresh load may start while the last entry still waits
// to be taken. Sums and products wrap at DATA_WIDTH bits and are sign-extended to 32 bits.
// Dimension registers hold 4 bits each; zero acts as one and anything above MAX_DIM as
// MAX_DIM. A register write is taken only between runs and restarts the load. The element
// stores have no reset: a run always writes every entry before it reads it.
// depends on imm_pkg, imm_ctrl, imm_dp and the channel interfaces
`timescale 1ns / 1ps

module integer_matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  imm_in_if.sink     in_if,
  imm_out_if.source  out_if,
  imm_cfg_if.sink    cfg_if
);
  import imm_pkg::*;

  // store address width, at least one bit
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  imm_cmd_t      cmd;
  imm_sts_t      sts;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] a_rd_addr;
  logic [AW-1:0] b_rd_addr;

  // sequencer: load counting, entry walk, emit timing
  imm_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_if.valid),
    .cfg_index (cfg_if.reg_index),
    .cfg_data  (cfg_if.wr_data),
    .cfg_ready (cfg_if.ready),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .sts       (sts),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .a_rd_addr (a_rd_addr),
    .b_rd_addr (b_rd_addr)
  );

  // stores, multiply-accumulate and output register
  imm_dp #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .wr_addr   (wr_addr),
    .a_rd_addr (a_rd_addr),
    .b_rd_addr (b_rd_addr),
    .in_data   (in_if.element_value),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_value (out_if.product_value),
    .out_row   (out_if.row_index),
    .out_col   (out_if.col_index),
    .out_last  (out_if.last_result)
  );

endmodule
